// ----- rtl/srs_pkg.sv -----
// shared types, codes and arithmetic helpers for the sparse row store
// used by srs_ctrl, srs_dp and sparse_row_store_with_slack
package srs_pkg;

    localparam int POOL_SLOTS_DEF = 4096;
    localparam int MAX_ROWS_DEF   = 256;

    localparam int CMD_W    = 2;
    localparam int ROW_W    = 8;
    localparam int COL_W    = 16;
    localparam int VAL_W    = 32;
    localparam int ST_W     = 3;
    localparam int CNT_W    = 13;
    localparam int RATIO_W  = 10;
    localparam int NROWS_W  = 9;
    localparam int NCOLS_W  = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 17;

    localparam logic [NROWS_W-1:0] NUM_ROWS_RST = 9'd256;
    localparam logic [NCOLS_W-1:0] NUM_COLS_RST = 17'd65536;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REM   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SCALE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_RATIO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS    = 2'd2;

    localparam logic [ST_W-1:0] ST_INSERTED    = 3'd0;
    localparam logic [ST_W-1:0] ST_ACCUMULATED = 3'd1;
    localparam logic [ST_W-1:0] ST_REMOVED     = 3'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND   = 3'd3;
    localparam logic [ST_W-1:0] ST_CLEARED     = 3'd4;
    localparam logic [ST_W-1:0] ST_SCALED      = 3'd5;
    localparam logic [ST_W-1:0] ST_FULL        = 3'd6;
    localparam logic [ST_W-1:0] ST_BAD         = 3'd7;

    // datapath micro-operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_ROW_RD, OP_ROW_CAP, OP_SRCH_RD, OP_SRCH_CMP,
        OP_HIT_RD, OP_ADD_WR, OP_REM_WR, OP_NXT_RD, OP_NXT_CAP, OP_INSERT,
        OP_CLEAR, OP_SCL_RD, OP_SCL_MUL, OP_SCL_WR, OP_LOOP_INIT, OP_LOOP_RD,
        OP_CNT_CAP, OP_SUM_ADD, OP_CP_RD, OP_CP_WR, OP_NEXT_ROW, OP_PL_SET,
        OP_PL_RD, OP_PL_WR, OP_PL_NEXT, OP_PL_END, OP_OUT
    } t_op;

    typedef struct packed {
        t_op             op;
        logic            st_we;
        logic [ST_W-1:0] st_val;
    } t_ctl;

    typedef struct packed {
        logic is_add;
        logic is_rem;
        logic is_clr;
        logic bad_row;
        logic bad_col;
        logic k_more;
        logic col_eq;
        logic need_lay;
        logic ins_full;
        logic rr_more;
        logic total_over;
        logic cp_more;
        logic pl_more;
        logic out_free;
    } t_flags;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi) begin
            return 32'sh7FFFFFFF;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return v[VAL_W-1:0];
    endfunction

    // q16.16 product: round half up, drop 16 fraction bits, saturate
    function automatic logic signed [VAL_W-1:0] qmul_round(input logic signed [63:0] prod);
        logic signed [63:0] p;
        p = prod + 64'sd32768;
        return sat32(p >>> 16);
    endfunction

endpackage

// ----- rtl/srs_ram.sv -----
// generic single write port, single read port ram with registered read
// no package dependency
module srs_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/srs_ctrl.sv -----
// sequencer for the sparse row store: walks each command through its steps
// depends on srs_pkg for the op codes, status codes and flag/command structs
module srs_ctrl import srs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_flags i_flags,
    output t_ctl   o_ctl
);

    typedef enum logic [30:0] {
        S_IDLE    = 31'h00000001,
        S_ROW_RD  = 31'h00000002,
        S_ROW_CAP = 31'h00000004,
        S_SRCH_RD = 31'h00000008,
        S_SRCH_CMP = 31'h00000010,
        S_HIT_RD  = 31'h00000020,
        S_HIT_WR  = 31'h00000040,
        S_NXT_RD  = 31'h00000080,
        S_NXT_CAP = 31'h00000100,
        S_NXT_CHK = 31'h00000200,
        S_INS_CHK = 31'h00000400,
        S_CLR     = 31'h00000800,
        S_SCL_RD  = 31'h00001000,
        S_SCL_MUL = 31'h00002000,
        S_SCL_WR  = 31'h00004000,
        S_SUM_RD  = 31'h00008000,
        S_SUM_CNT = 31'h00010000,
        S_SUM_ADD = 31'h00020000,
        S_SUM_CHK = 31'h00040000,
        S_CP_ROW  = 31'h00080000,
        S_CP_CAP  = 31'h00100000,
        S_CP_RD   = 31'h00200000,
        S_CP_WR   = 31'h00400000,
        S_PL_ROW  = 31'h00800000,
        S_PL_CNT  = 31'h01000000,
        S_PL_SET  = 31'h02000000,
        S_PL_RD   = 31'h04000000,
        S_PL_WR   = 31'h08000000,
        S_RE_RD   = 31'h10000000,
        S_DONE    = 31'h20000000,
        S_RE_CAP  = 31'h40000000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_ctl   w_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        w_ctl.op     = OP_NONE;
        w_ctl.st_we  = 1'b0;
        w_ctl.st_val = ST_BAD;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_ctl.op = OP_LOAD;
                    n_state  = S_ROW_RD;
                end
            end
            S_ROW_RD: begin
                w_ctl.op = OP_ROW_RD;
                n_state  = S_ROW_CAP;
            end
            S_ROW_CAP: begin
                w_ctl.op = OP_ROW_CAP;
                if (i_flags.bad_row ||
                    ((i_flags.is_add || i_flags.is_rem) && i_flags.bad_col)) begin
                    w_ctl.st_we  = 1'b1;
                    w_ctl.st_val = ST_BAD;
                    n_state      = S_DONE;
                end else if (i_flags.is_add || i_flags.is_rem) begin
                    n_state = S_SRCH_RD;
                end else if (i_flags.is_clr) begin
                    n_state = S_CLR;
                end else begin
                    n_state = S_SCL_RD;
                end
            end
            S_SRCH_RD: begin
                w_ctl.op = OP_SRCH_RD;
                if (i_flags.k_more) begin
                    n_state = S_SRCH_CMP;
                end else if (i_flags.is_rem) begin
                    w_ctl.st_we  = 1'b1;
                    w_ctl.st_val = ST_NOT_FOUND;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_NXT_RD;
                end
            end
            S_SRCH_CMP: begin
                w_ctl.op = OP_SRCH_CMP;
                n_state  = i_flags.col_eq ? S_HIT_RD : S_SRCH_RD;
            end
            S_HIT_RD: begin
                w_ctl.op = OP_HIT_RD;
                n_state  = S_HIT_WR;
            end
            S_HIT_WR: begin
                w_ctl.st_we = 1'b1;
                if (i_flags.is_add) begin
                    w_ctl.op     = OP_ADD_WR;
                    w_ctl.st_val = ST_ACCUMULATED;
                end else begin
                    w_ctl.op     = OP_REM_WR;
                    w_ctl.st_val = ST_REMOVED;
                end
                n_state = S_DONE;
            end
            S_NXT_RD: begin
                w_ctl.op = OP_NXT_RD;
                n_state  = S_NXT_CAP;
            end
            S_NXT_CAP: begin
                w_ctl.op = OP_NXT_CAP;
                n_state  = S_NXT_CHK;
            end
            S_NXT_CHK: begin
                if (i_flags.need_lay) begin
                    w_ctl.op = OP_LOOP_INIT;
                    n_state  = S_SUM_RD;
                end else begin
                    n_state = S_INS_CHK;
                end
            end
            S_INS_CHK: begin
                w_ctl.st_we = 1'b1;
                if (i_flags.ins_full) begin
                    w_ctl.st_val = ST_FULL;
                end else begin
                    w_ctl.op     = OP_INSERT;
                    w_ctl.st_val = ST_INSERTED;
                end
                n_state = S_DONE;
            end
            S_CLR: begin
                w_ctl.op     = OP_CLEAR;
                w_ctl.st_we  = 1'b1;
                w_ctl.st_val = ST_CLEARED;
                n_state      = S_DONE;
            end
            S_SCL_RD: begin
                if (i_flags.k_more) begin
                    w_ctl.op = OP_SCL_RD;
                    n_state  = S_SCL_MUL;
                end else begin
                    w_ctl.st_we  = 1'b1;
                    w_ctl.st_val = ST_SCALED;
                    n_state      = S_DONE;
                end
            end
            S_SCL_MUL: begin
                w_ctl.op = OP_SCL_MUL;
                n_state  = S_SCL_WR;
            end
            S_SCL_WR: begin
                w_ctl.op = OP_SCL_WR;
                n_state  = S_SCL_RD;
            end
            // first pass over the rows: size of the new layout
            S_SUM_RD: begin
                if (i_flags.rr_more) begin
                    w_ctl.op = OP_LOOP_RD;
                    n_state  = S_SUM_CNT;
                end else begin
                    n_state = S_SUM_CHK;
                end
            end
            S_SUM_CNT: begin
                w_ctl.op = OP_CNT_CAP;
                n_state  = S_SUM_ADD;
            end
            S_SUM_ADD: begin
                w_ctl.op = OP_SUM_ADD;
                n_state  = S_SUM_RD;
            end
            S_SUM_CHK: begin
                if (i_flags.total_over) begin
                    w_ctl.st_we  = 1'b1;
                    w_ctl.st_val = ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    w_ctl.op = OP_LOOP_INIT;
                    n_state  = S_CP_ROW;
                end
            end
            // second pass: pack all entries into scratch
            S_CP_ROW: begin
                if (i_flags.rr_more) begin
                    w_ctl.op = OP_LOOP_RD;
                    n_state  = S_CP_CAP;
                end else begin
                    w_ctl.op = OP_LOOP_INIT;
                    n_state  = S_PL_ROW;
                end
            end
            S_CP_CAP: begin
                w_ctl.op = OP_ROW_CAP;
                n_state  = S_CP_RD;
            end
            S_CP_RD: begin
                if (i_flags.cp_more) begin
                    w_ctl.op = OP_CP_RD;
                    n_state  = S_CP_WR;
                end else begin
                    w_ctl.op = OP_NEXT_ROW;
                    n_state  = S_CP_ROW;
                end
            end
            S_CP_WR: begin
                w_ctl.op = OP_CP_WR;
                n_state  = S_CP_RD;
            end
            // third pass: place rows back with their spare slots
            S_PL_ROW: begin
                if (i_flags.rr_more) begin
                    w_ctl.op = OP_LOOP_RD;
                    n_state  = S_PL_CNT;
                end else begin
                    w_ctl.op = OP_PL_END;
                    n_state  = S_RE_RD;
                end
            end
            S_PL_CNT: begin
                w_ctl.op = OP_CNT_CAP;
                n_state  = S_PL_SET;
            end
            S_PL_SET: begin
                w_ctl.op = OP_PL_SET;
                n_state  = S_PL_RD;
            end
            S_PL_RD: begin
                if (i_flags.pl_more) begin
                    w_ctl.op = OP_PL_RD;
                    n_state  = S_PL_WR;
                end else begin
                    w_ctl.op = OP_PL_NEXT;
                    n_state  = S_PL_ROW;
                end
            end
            S_PL_WR: begin
                w_ctl.op = OP_PL_WR;
                n_state  = S_PL_RD;
            end
            // after a layout the row is read again and captured on the way back
            S_RE_RD: begin
                w_ctl.op = OP_ROW_RD;
                n_state  = S_RE_CAP;
            end
            S_RE_CAP: begin
                w_ctl.op = OP_ROW_CAP;
                n_state  = S_INS_CHK;
            end
            S_DONE: begin
                if (i_flags.out_free) begin
                    w_ctl.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_ctl      = w_ctl;

endmodule

// ----- rtl/srs_dp.sv -----
// datapath of the sparse row store: pool, row table, scratch, counters, arithmetic
// depends on srs_pkg and srs_ram
module srs_dp import srs_pkg::*; #(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF,
    parameter int MAX_ROWS   = MAX_ROWS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_ctl                        i_ctl,
    output t_flags                      o_flags,
    input  logic [CMD_W-1:0]            i_command,
    input  logic [ROW_W-1:0]            i_row_index,
    input  logic [COL_W-1:0]            i_column_index,
    input  logic signed [VAL_W-1:0]     i_operand_value,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DAT_W-1:0]        i_cfg_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [ST_W-1:0]             o_status,
    output logic [CNT_W-1:0]            o_row_entries,
    output logic [CNT_W-1:0]            o_free_slots
);

    localparam int SW = $clog2(POOL_SLOTS + 1);
    localparam int AW = $clog2(POOL_SLOTS);
    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam int TW = SW + RW + 12;
    localparam int PW = SW + RATIO_W;
    localparam logic [SW-1:0] POOL_V = SW'(POOL_SLOTS);

    // configuration and control state
    logic [RATIO_W-1:0] r_spare_ratio;
    logic [NROWS_W-1:0] r_num_rows;
    logic [NCOLS_W-1:0] r_num_cols;
    logic [MAX_ROWS:0]  r_rvalid;
    logic [SW-1:0]      r_free;
    logic               r_out_valid;

    // item and working registers
    logic [CMD_W-1:0]        r_cmd;
    logic [ROW_W-1:0]        r_row;
    logic [COL_W-1:0]        r_col;
    logic signed [VAL_W-1:0] r_val;
    logic [SW-1:0]           r_start;
    logic [SW-1:0]           r_end;
    logic [SW-1:0]           r_nstart;
    logic [SW-1:0]           r_k;
    logic [SW-1:0]           r_n;
    logic [RW-1:0]           r_rr;
    logic [SW-1:0]           r_off;
    logic [SW-1:0]           r_noff;
    logic [SW-1:0]           r_cnt;
    logic [TW-1:0]           r_total;
    logic signed [63:0]      r_prod;
    logic                    r_rv_q;
    logic [ST_W-1:0]         r_status;
    logic [ST_W-1:0]         r_out_status;
    logic [CNT_W-1:0]        r_out_entries;
    logic [CNT_W-1:0]        r_out_free;

    t_op                     op;
    logic [RW-1:0]           w_rows;
    logic [SW-1:0]           w_cur_cnt;
    logic [SW-1:0]           w_row_s;
    logic [SW-1:0]           w_row_e;
    logic [SW-1:0]           w_rd_cnt;
    logic [PW-1:0]           w_sp_prod;
    logic [PW-1:0]           w_spare;
    logic signed [VAL_W-1:0] w_val_rd;
    logic [COL_W-1:0]        w_col_rd;
    logic [VAL_W+COL_W-1:0]  w_scr_rd;
    logic [2*SW-1:0]         w_row_rd;
    logic signed [VAL_W:0]   w_sum;
    logic [SW:0]             w_pl_addr;

    logic [AW-1:0]           w_pool_raddr;
    logic [AW-1:0]           w_pool_waddr;
    logic                    w_val_we;
    logic                    w_col_we;
    logic [VAL_W-1:0]        w_val_wdata;
    logic [COL_W-1:0]        w_col_wdata;
    logic                    w_row_we;
    logic [RW-1:0]           w_row_raddr;
    logic [RW-1:0]           w_row_waddr;
    logic [2*SW-1:0]         w_row_wdata;
    logic                    w_scr_we;

    assign op = i_ctl.op;

    assign w_rows = (32'(r_num_rows) > 32'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(r_num_rows);

    assign w_cur_cnt = (r_end >= r_start) ? SW'(r_end - r_start) : '0;
    assign w_row_s   = r_rv_q ? w_row_rd[2*SW-1:SW] : '0;
    assign w_row_e   = r_rv_q ? w_row_rd[SW-1:0] : '0;
    assign w_rd_cnt  = (w_row_e >= w_row_s) ? SW'(w_row_e - w_row_s) : '0;
    assign w_sp_prod = PW'(r_cnt) * PW'(r_spare_ratio);
    assign w_spare   = w_sp_prod >> 8;
    assign w_sum     = {w_val_rd[VAL_W-1], w_val_rd} + {r_val[VAL_W-1], r_val};
    assign w_pl_addr = (SW+1)'(r_off) + (SW+1)'(r_k);

    // status toward the controller
    always_comb begin
        o_flags.is_add     = (r_cmd == CMD_ADD);
        o_flags.is_rem     = (r_cmd == CMD_REM);
        o_flags.is_clr     = (r_cmd == CMD_CLEAR);
        o_flags.bad_row    = (32'(r_row) >= 32'(w_rows));
        o_flags.bad_col    = (NCOLS_W'(r_col) >= r_num_cols);
        o_flags.k_more     = (r_k < r_end) && (r_k < POOL_V);
        o_flags.col_eq     = (w_col_rd == r_col);
        o_flags.need_lay   = (r_end >= r_nstart);
        o_flags.ins_full   = (r_end >= POOL_V) || (r_free == '0);
        o_flags.rr_more    = (r_rr < w_rows);
        o_flags.total_over = (r_total > TW'(POOL_SLOTS));
        o_flags.cp_more    = (r_k < r_end) && (r_k < POOL_V) && (r_n < POOL_V);
        o_flags.pl_more    = (r_k < r_cnt) && (w_pl_addr < (SW+1)'(POOL_SLOTS)) &&
                             (r_n < POOL_V);
        o_flags.out_free   = !r_out_valid || i_out_ready;
    end

    // pool ports
    always_comb begin
        w_pool_raddr = AW'(r_k);
        if (op == OP_HIT_RD && r_cmd == CMD_REM) begin
            w_pool_raddr = AW'(r_end - 1'b1);
        end
        case (op) inside
            OP_ADD_WR, OP_SCL_WR, OP_REM_WR, OP_INSERT, OP_PL_WR: w_val_we = 1'b1;
            default: w_val_we = 1'b0;
        endcase
        case (op) inside
            OP_REM_WR, OP_INSERT, OP_PL_WR: w_col_we = 1'b1;
            default: w_col_we = 1'b0;
        endcase
        w_pool_waddr = AW'(r_k);
        w_val_wdata  = w_val_rd;
        w_col_wdata  = w_col_rd;
        case (op)
            OP_ADD_WR: w_val_wdata = sat32(w_sum);
            OP_SCL_WR: w_val_wdata = qmul_round(r_prod);
            OP_INSERT: begin
                w_pool_waddr = AW'(r_end);
                w_val_wdata  = r_val;
                w_col_wdata  = r_col;
            end
            OP_PL_WR: begin
                w_pool_waddr = AW'(w_pl_addr);
                w_val_wdata  = w_scr_rd[VAL_W+COL_W-1:COL_W];
                w_col_wdata  = w_scr_rd[COL_W-1:0];
            end
            default: begin
                w_pool_waddr = AW'(r_k);
            end
        endcase
    end

    // row table ports
    always_comb begin
        case (op)
            OP_ROW_RD: w_row_raddr = RW'(r_row);
            OP_NXT_RD: w_row_raddr = RW'(32'(r_row) + 1);
            default:   w_row_raddr = r_rr;
        endcase
        case (op) inside
            OP_REM_WR, OP_INSERT, OP_CLEAR, OP_PL_SET, OP_PL_END: w_row_we = 1'b1;
            default: w_row_we = 1'b0;
        endcase
        w_row_waddr = RW'(r_row);
        w_row_wdata = {r_start, r_end};
        case (op)
            OP_REM_WR: w_row_wdata = {r_start, SW'(r_end - 1'b1)};
            OP_INSERT: w_row_wdata = {r_start, SW'(r_end + 1'b1)};
            OP_CLEAR:  w_row_wdata = {r_start, r_start};
            OP_PL_SET: begin
                w_row_waddr = r_rr;
                w_row_wdata = {r_off, SW'(r_off + r_cnt)};
            end
            OP_PL_END: begin
                w_row_waddr = w_rows;
                w_row_wdata = {r_off, r_off};
            end
            default: begin
                w_row_waddr = RW'(r_row);
            end
        endcase
    end

    assign w_scr_we = (op == OP_CP_WR);

    srs_ram #(.WIDTH(VAL_W), .DEPTH(POOL_SLOTS)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (w_val_we),
        .i_waddr (w_pool_waddr),
        .i_wdata (w_val_wdata),
        .i_raddr (w_pool_raddr),
        .o_rdata (w_val_rd)
    );

    srs_ram #(.WIDTH(COL_W), .DEPTH(POOL_SLOTS)) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (w_col_we),
        .i_waddr (w_pool_waddr),
        .i_wdata (w_col_wdata),
        .i_raddr (w_pool_raddr),
        .o_rdata (w_col_rd)
    );

    srs_ram #(.WIDTH(VAL_W + COL_W), .DEPTH(POOL_SLOTS)) u_scr_ram (
        .i_clk   (i_clk),
        .i_we    (w_scr_we),
        .i_waddr (AW'(r_n)),
        .i_wdata ({w_val_rd, w_col_rd}),
        .i_raddr (AW'(r_n)),
        .o_rdata (w_scr_rd)
    );

    srs_ram #(.WIDTH(2 * SW), .DEPTH(MAX_ROWS + 1)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_row_we),
        .i_waddr (w_row_waddr),
        .i_wdata (w_row_wdata),
        .i_raddr (w_row_raddr),
        .o_rdata (w_row_rd)
    );

    // control state: registers, row valid bits, free count, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spare_ratio <= '0;
            r_num_rows    <= NUM_ROWS_RST;
            r_num_cols    <= NUM_COLS_RST;
            r_rvalid      <= '0;
            r_free        <= POOL_V;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SPARE_RATIO: r_spare_ratio <= i_cfg_data[RATIO_W-1:0];
                    CFG_NUM_ROWS: begin
                        r_num_rows <= i_cfg_data[NROWS_W-1:0];
                        r_rvalid   <= '0;
                        r_free     <= POOL_V;
                    end
                    CFG_NUM_COLS: r_num_cols <= i_cfg_data[NCOLS_W-1:0];
                    default: begin
                        r_num_cols <= r_num_cols;
                    end
                endcase
            end
            if (w_row_we) begin
                r_rvalid[w_row_waddr] <= 1'b1;
            end
            case (op)
                OP_REM_WR: r_free <= SW'(r_free + 1'b1);
                OP_INSERT: r_free <= SW'(r_free - 1'b1);
                OP_CLEAR:  r_free <= SW'(r_free + w_cur_cnt);
                default: begin
                end
            endcase
            if (op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_rv_q <= r_rvalid[w_row_raddr];
        if (i_ctl.st_we) begin
            r_status <= i_ctl.st_val;
        end
        case (op)
            OP_LOAD: begin
                r_cmd <= i_command;
                r_row <= i_row_index;
                r_col <= i_column_index;
                r_val <= i_operand_value;
            end
            OP_ROW_CAP: begin
                r_start <= w_row_s;
                r_end   <= w_row_e;
                r_k     <= w_row_s;
            end
            OP_SRCH_CMP: begin
                if (w_col_rd != r_col) begin
                    r_k <= SW'(r_k + 1'b1);
                end
            end
            OP_REM_WR: r_end <= SW'(r_end - 1'b1);
            OP_NXT_CAP: r_nstart <= w_row_s;
            OP_INSERT: r_end <= SW'(r_end + 1'b1);
            OP_CLEAR: r_end <= r_start;
            OP_SCL_MUL: r_prod <= w_val_rd * r_val;
            OP_SCL_WR: r_k <= SW'(r_k + 1'b1);
            OP_LOOP_INIT: begin
                r_rr    <= '0;
                r_n     <= '0;
                r_off   <= '0;
                r_total <= '0;
            end
            OP_CNT_CAP: r_cnt <= w_rd_cnt;
            OP_SUM_ADD: begin
                r_total <= r_total + TW'(r_cnt) + TW'(w_spare) + TW'(1);
                r_rr    <= RW'(r_rr + 1'b1);
            end
            OP_CP_WR: begin
                r_n <= SW'(r_n + 1'b1);
                r_k <= SW'(r_k + 1'b1);
            end
            OP_NEXT_ROW: r_rr <= RW'(r_rr + 1'b1);
            OP_PL_SET: begin
                r_noff <= SW'(TW'(r_off) + TW'(r_cnt) + TW'(w_spare) + TW'(1));
                r_k    <= '0;
            end
            OP_PL_WR: begin
                r_n <= SW'(r_n + 1'b1);
                r_k <= SW'(r_k + 1'b1);
            end
            OP_PL_NEXT: begin
                r_off <= r_noff;
                r_rr  <= RW'(r_rr + 1'b1);
            end
            OP_OUT: begin
                r_out_status  <= r_status;
                r_out_entries <= o_flags.bad_row ? '0 : CNT_W'(w_cur_cnt);
                r_out_free    <= CNT_W'(r_free);
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_row_entries = r_out_entries;
    assign o_free_slots  = r_out_free;

    // free count can never pass the pool size
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= POOL_V)
        else $error("free count above pool size");

    // an append only goes to a slot that exists and is free
    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        op == OP_INSERT |-> !o_flags.ins_full)
        else $error("append into a full segment or pool");

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        op == OP_OUT |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    // an append takes exactly one free slot
    a_insert_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        op == OP_INSERT |=> r_free == SW'($past(r_free) - 1'b1))
        else $error("free count not taken on append");

endmodule

// ----- rtl/sparse_row_store_with_slack.sv -----
// Row-wise sparse matrix store in one pool of POOL_SLOTS Q16.16 entries, each row owning
// a segment with spare slots. Add and remove search the row entry by entry and scale
// reads, multiplies and writes back each entry, all through the single-read pool memory.
// An add that finds its segment full first rebuilds the layout in passes over the rows:
// one to size it, one to copy the stored entries out to scratch and one to place them
// back with their spare slots, all through the one pool read port. No clearing pass
// after reset: the row table carries valid bits.
// depends on srs_pkg, srs_ctrl, srs_dp and srs_ram
module sparse_row_store_with_slack import srs_pkg::*; #(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF,
    parameter int MAX_ROWS   = MAX_ROWS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [CMD_W-1:0]        i_command,
    input  logic [ROW_W-1:0]        i_row_index,
    input  logic [COL_W-1:0]        i_column_index,
    input  logic signed [VAL_W-1:0] i_operand_value,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [ST_W-1:0]         o_status,
    output logic [CNT_W-1:0]        o_row_entries,
    output logic [CNT_W-1:0]        o_free_slots,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DAT_W-1:0]    i_cfg_data
);

    t_ctl   w_ctl;
    t_flags w_flags;

    srs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_flags    (w_flags),
        .o_ctl      (w_ctl)
    );

    srs_dp #(
        .POOL_SLOTS (POOL_SLOTS),
        .MAX_ROWS   (MAX_ROWS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl),
        .o_flags         (w_flags),
        .i_command       (i_command),
        .i_row_index     (i_row_index),
        .i_column_index  (i_column_index),
        .i_operand_value (i_operand_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_row_entries   (o_row_entries),
        .o_free_slots    (o_free_slots)
    );

endmodule

// ----- tb/sv/tb.sv -----
// testbench for sparse_row_store_with_slack: random and directed row commands,
// a scoreboard class keeps its own copy of the row store and checks each result word
// depends on srs_pkg and the rtl of sparse_row_store_with_slack
`timescale 1ns / 100ps

module tb;
    import srs_pkg::*;

    localparam int POOL = 4096;
    localparam int MROWS = 256;
    localparam int WATCHDOG = 200000;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] entries;
        logic [CNT_W-1:0] free_slots;
    } t_result;

    class row_store_board;
        logic signed [31:0] vals[POOL];
        logic [15:0]        cols[POOL];
        logic signed [31:0] scr_vals[POOL];
        logic [15:0]        scr_cols[POOL];
        int unsigned        rstart[MROWS+1];
        int unsigned        rend[MROWS+1];
        int unsigned        free_cnt;
        int unsigned        ratio;
        int unsigned        nrows;
        int unsigned        ncols;
        t_result            pending[$];
        int                 errors;

        function void wipe();
            foreach (rstart[i]) begin
                rstart[i] = 0;
                rend[i] = 0;
            end
            free_cnt = POOL;
        endfunction

        function void reset_state();
            ratio = 0;
            nrows = 256;
            ncols = 65536;
            errors = 0;
            wipe();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
            if (idx == CFG_SPARE_RATIO) begin
                ratio = data & 'h3FF;
            end else if (idx == CFG_NUM_ROWS) begin
                nrows = data & 'h1FF;
                wipe();
            end else if (idx == CFG_NUM_COLS) begin
                ncols = data & 'h1FFFF;
            end
        endfunction

        function int unsigned count_of(int unsigned r);
            return rend[r] >= rstart[r] ? rend[r] - rstart[r] : 0;
        endfunction

        function logic signed [31:0] clamp(longint v);
            if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[31:0];
        endfunction

        // rebuild every row with floor(count*ratio/256)+1 spare slots
        function bit relay(int unsigned m);
            longint total;
            int unsigned off, n, c;
            total = 0;
            off = 0;
            n = 0;
            for (int r = 0; r < m; r++) begin
                c = count_of(r);
                total += c + ((longint'(c) * ratio) >> 8) + 1;
            end
            if (total > POOL) return 0;
            for (int r = 0; r < m; r++)
                for (int k = rstart[r]; k < rend[r] && k < POOL && n < POOL; k++) begin
                    scr_vals[n] = vals[k];
                    scr_cols[n] = cols[k];
                    n++;
                end
            n = 0;
            for (int r = 0; r < m; r++) begin
                c = count_of(r);
                rstart[r] = off;
                for (int k = 0; k < c; k++) begin
                    vals[off+k] = scr_vals[n];
                    cols[off+k] = scr_cols[n];
                    n++;
                end
                rend[r] = off + c;
                off += c + ((c * ratio) >> 8) + 1;
            end
            rstart[m] = off;
            rend[m] = off;
            return 1;
        endfunction

        function void note_word(logic [1:0] cmd, int unsigned r, int unsigned col,
                                logic signed [31:0] v);
            t_result res;
            int unsigned m, hit, last;
            longint p;
            m = nrows > MROWS ? MROWS : nrows;
            hit = POOL;
            res.entries = 0;
            if (r >= m) begin
                res.status = ST_BAD;
            end else if (cmd <= CMD_REM && col >= ncols) begin
                res.status = ST_BAD;
                res.entries = CNT_W'(count_of(r));
            end else begin
                if (cmd <= CMD_REM)
                    for (int k = rstart[r]; k < rend[r] && k < POOL; k++)
                        if (cols[k] == col) begin
                            hit = k;
                            break;
                        end
                if (cmd == CMD_ADD) begin
                    if (hit < POOL) begin
                        vals[hit] = clamp(longint'(vals[hit]) + longint'(v));
                        res.status = ST_ACCUMULATED;
                    end else if (rend[r] >= rstart[r+1] && !relay(m)) begin
                        res.status = ST_FULL;
                    end else if (rend[r] >= POOL || free_cnt == 0) begin
                        res.status = ST_FULL;
                    end else begin
                        cols[rend[r]] = col[15:0];
                        vals[rend[r]] = v;
                        rend[r]++;
                        free_cnt--;
                        res.status = ST_INSERTED;
                    end
                end else if (cmd == CMD_REM) begin
                    if (hit < POOL) begin
                        last = rend[r] - 1;
                        vals[hit] = vals[last];
                        cols[hit] = cols[last];
                        rend[r] = last;
                        free_cnt++;
                        res.status = ST_REMOVED;
                    end else begin
                        res.status = ST_NOT_FOUND;
                    end
                end else if (cmd == CMD_CLEAR) begin
                    free_cnt += count_of(r);
                    rend[r] = rstart[r];
                    res.status = ST_CLEARED;
                end else begin
                    // round half up: arithmetic shift floors
                    for (int k = rstart[r]; k < rend[r] && k < POOL; k++) begin
                        p = longint'(vals[k]) * longint'(v) + 64'sd32768;
                        vals[k] = clamp(p >>> 16);
                    end
                    res.status = ST_SCALED;
                end
                res.entries = CNT_W'(count_of(r));
            end
            res.free_slots = CNT_W'(free_cnt);
            pending = {pending, res};
        endfunction

        function void check_word(t_result got);
            t_result exp_res;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result word status %0d", $time, got.status);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (got.status !== exp_res.status) begin
                $display("%0t: status expected %0d actual %0d", $time,
                         exp_res.status, got.status);
                errors++;
            end
            if (got.entries !== exp_res.entries) begin
                $display("%0t: row_entries expected %0d actual %0d", $time,
                         exp_res.entries, got.entries);
                errors++;
            end
            if (got.free_slots !== exp_res.free_slots) begin
                $display("%0t: free_slots expected %0d actual %0d", $time,
                         exp_res.free_slots, got.free_slots);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk = 0;
    logic                    i_rst_n = 0;
    logic                    i_in_valid = 0;
    logic                    o_in_ready;
    logic [CMD_W-1:0]        i_command = '0;
    logic [ROW_W-1:0]        i_row_index = '0;
    logic [COL_W-1:0]        i_column_index = '0;
    logic signed [VAL_W-1:0] i_operand_value = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 0;
    logic [ST_W-1:0]         o_status;
    logic [CNT_W-1:0]        o_row_entries;
    logic [CNT_W-1:0]        o_free_slots;
    logic                    i_cfg_we = 0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]    i_cfg_data = '0;

    row_store_board board = new();
    bit   calm = 0;
    int   stall_cycles = 0;

    sparse_row_store_with_slack dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // result side: random back-pressure, checks every accepted word
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready)
            board.check_word('{o_status, o_row_entries, o_free_slots});
        i_out_ready <= calm || ($urandom_range(99) >= 35);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // valid stays up from one word to the next unless an idle cycle comes between
    task automatic send_word(logic [1:0] cmd, int unsigned r, int unsigned col,
                             logic signed [31:0] v);
        while (!calm && $urandom_range(99) < 35) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_command <= cmd;
        i_row_index <= ROW_W'(r);
        i_column_index <= COL_W'(col);
        i_operand_value <= v;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_word(cmd, r, col, v);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
        drain();
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_DAT_W'(data);
        @(posedge i_clk);
        i_cfg_we <= 0;
        board.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_val();
        case ($urandom_range(5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $urandom_range(131072) - 65536;
            default: return $urandom;
        endcase
    endfunction

    // mostly valid rows and a small column set so hits and removes land
    task automatic random_phase(int n, int unsigned row_span, int unsigned col_span);
        int unsigned r, c;
        logic [1:0] cmd;
        for (int i = 0; i < n; i++) begin
            r = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(row_span - 1);
            c = ($urandom_range(19) == 0) ? $urandom_range(65535) : $urandom_range(col_span - 1);
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9: cmd = CMD_ADD;
                10, 11, 12, 13, 14: cmd = CMD_REM;
                15: cmd = CMD_CLEAR;
                default: cmd = CMD_SCALE;
            endcase
            send_word(cmd, r, c, rand_val());
        end
    endtask

    initial begin
        board.reset_state();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, all commands, bad row and column, missing entry
        calm = 1;
        send_word(CMD_ADD, 0, 0, 32'sh7FFFFFFF);
        send_word(CMD_ADD, 0, 0, 32'sh7FFFFFFF);
        send_word(CMD_ADD, 0, 65535, 32'sh80000000);
        send_word(CMD_ADD, 0, 65535, 32'sh80000000);
        send_word(CMD_ADD, 255, 12345, 32'sh00018000);
        send_word(CMD_SCALE, 255, 0, 32'sh00008000);
        send_word(CMD_SCALE, 255, 0, 32'shFFFF8000);
        send_word(CMD_SCALE, 0, 0, 32'sh7FFFFFFF);
        send_word(CMD_REM, 0, 7, 0);
        send_word(CMD_REM, 0, 0, 0);
        send_word(CMD_CLEAR, 0, 0, 0);
        send_word(CMD_CLEAR, 17, 0, 0);
        calm = 0;
        write_cfg(CFG_NUM_COLS, 1);
        send_word(CMD_ADD, 3, 1, 5);
        send_word(CMD_REM, 3, 65535, 5);
        send_word(CMD_ADD, 3, 0, 5);
        write_cfg(CFG_NUM_ROWS, 4);
        send_word(CMD_ADD, 4, 0, 5);
        send_word(CMD_ADD, 255, 0, 5);
        write_cfg(CFG_NUM_ROWS, 0);
        send_word(CMD_SCALE, 0, 0, 5);
        write_cfg(CFG_NUM_ROWS, 300);
        send_word(CMD_CLEAR, 255, 0, 0);

        // small store, no spare: relayouts and full conditions come often
        write_cfg(CFG_SPARE_RATIO, 0);
        write_cfg(CFG_NUM_COLS, 65536);
        write_cfg(CFG_NUM_ROWS, 8);
        random_phase(250, 8, 32);
        write_cfg(CFG_SPARE_RATIO, 1023);
        random_phase(200, 8, 64);
        // pool pressure: wide ratio, many rows, many distinct columns
        write_cfg(CFG_NUM_ROWS, 64);
        calm = 1;
        random_phase(200, 64, 4096);
        calm = 0;
        write_cfg(CFG_SPARE_RATIO, 128);
        write_cfg(CFG_NUM_COLS, 40);
        random_phase(200, 64, 48);
        write_cfg(CFG_NUM_ROWS, 256);
        write_cfg(CFG_NUM_COLS, 65536);
        write_cfg(CFG_SPARE_RATIO, 300);
        random_phase(150, 256, 65536);

        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/srs_pkg.sv
rtl/srs_ram.sv
rtl/srs_ctrl.sv
rtl/srs_dp.sv
rtl/sparse_row_store_with_slack.sv
tb/sv/tb.sv
